FILE: rtl/core/tlca_pkg.sv
package tlca_pkg;

    // Sizes of the tree and of the lifting table.
    localparam int MAX_NODES  = 1024;
    localparam int LEVELS     = 11;
    localparam int NODE_W     = 11;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int SLOT_W     = $clog2(2 * MAX_NODES);
    localparam int PTR_W      = SLOT_W + 1;
    localparam int K_W        = $clog2(LEVELS);
    localparam int JUMP_DEPTH = (MAX_NODES + 1) * LEVELS;
    localparam int JADDR_W    = $clog2(JUMP_DEPTH);

    // Register index of node_count on the configuration port.
    localparam logic REG_NODE_COUNT = 1'b0;

    // Request item and result item.
    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              bad_node;
    } t_out_item;

    // One adjacency list entry and one walk stack frame.
    typedef struct packed {
        logic [PTR_W-1:0]  link;
        logic [NODE_W-1:0] target;
    } t_list_entry;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] lvl;
    } t_frame;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_DECIDE,
        S_E_RDA, S_E_WRA, S_E_RDB, S_E_WRB,
        S_B_INIT, S_B_ENT, S_B_HEAD, S_B_JWR, S_B_CUR, S_B_CURW,
        S_B_POP, S_B_LNK, S_B_LVL,
        S_Q_START, S_Q_LA, S_Q_LB, S_Q_LIFT, S_Q_LIFTW, S_Q_CMP,
        S_Q_UA, S_Q_UB, S_Q_UC, S_Q_FIN, S_Q_FINW, S_Q_OUT
    } t_state;

    typedef enum logic [5:0] {
        OP_NONE, OP_CLR, OP_LOAD,
        OP_E_RDA, OP_E_WRA, OP_E_RDB, OP_E_WRB,
        OP_B_INIT, OP_B_ENT, OP_B_HEAD, OP_B_JWR, OP_B_CUR,
        OP_B_POP, OP_B_TOP, OP_B_LINK, OP_B_LNKW, OP_B_ENTQ, OP_B_DONE,
        OP_Q_BAD, OP_Q_SAME, OP_Q_ROOT, OP_Q_ZERO, OP_Q_RDLA, OP_Q_LVLA, OP_Q_LVLB,
        OP_LIFT, OP_KDEC, OP_LIFTW, OP_CMP_INIT, OP_UP_RDA, OP_UP_RDB, OP_UP_CMP,
        OP_FIN_RD, OP_FIN_W, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic kind;
        logic edge_ok;
        logic have_edges;
        logic ready;
        logic range_bad;
        logic same;
        logic has_root;
        logic k_last;
        logic cur_zero;
        logic top_one;
        logic lvl_free;
        logic lvl_zero;
        logic gap_bit;
        logic k_zero;
        logic out_free;
    } t_stat;

    // Address of ancestor level k of a node in the lifting table.
    function automatic logic [JADDR_W-1:0] jump_addr(input logic [NODE_W-1:0] node,
                                                     input logic [K_W-1:0] k);
        jump_addr = JADDR_W'(JADDR_W'(node) * JADDR_W'(LEVELS) + JADDR_W'(k));
    endfunction

endpackage

FILE: rtl/core/tree_lca_binary_lifting_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_in_data  (kind, node_a, node_b)
// result    out        o_out_valid / i_out_stall o_out_data (ancestor, bad_node)
// config    in         APB write/read            node_count at address 0
//
// After reset a clearing pass empties the adjacency lists and depths of all nodes;
// no request is taken during it. An edge reads and writes the list head of each end
// in turn. The first query of a full tree runs the walk first: it enters and pops each
// node and follows each list entry, one step after another through the single read
// port of each memory. A query then lifts the deeper node by the depth gap, bit by bit,
// and compares the two ancestors at each table level, all through one table port.
// A request is taken while a result waits; a new result waits for the output register.
module tree_lca_binary_lifting_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tlca_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tlca_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tlca_pkg::*;

    logic [10:0] r_node_count;
    t_cmd        cmd;
    t_stat       stat;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 11'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
            r_node_count <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {21'b0, r_node_count} : 32'b0;

    tlca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_stat(stat), .o_cmd(cmd)
    );

    tlca_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_in_data(i_in_data), .i_node_count(r_node_count),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid), .o_out_data(o_out_data)
    );

endmodule

FILE: rtl/core/tlca_ram.sv
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tlca_dp.sv
module tlca_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlca_pkg::t_cmd     i_cmd,
    output tlca_pkg::t_stat    o_stat,
    input  tlca_pkg::t_in_item i_in_data,
    input  logic [10:0]        i_node_count,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output tlca_pkg::t_out_item o_out_data
);
    import tlca_pkg::*;

    // Request fields and control state.
    logic              r_kind, n_kind;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic [NODE_W-1:0] r_edges, n_edges;
    logic              r_ready, n_ready;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [NODE_W-1:0] r_top, n_top;
    logic [NODE_W-1:0] r_v, n_v, r_up, n_up, r_lvl, n_lvl;
    logic [K_W-1:0]    r_k, n_k;
    logic [NODE_W-1:0] r_tnode, n_tnode, r_tlvl, n_tlvl, r_nb, n_nb;
    logic [NODE_W-1:0] r_la, n_la, r_gap, n_gap, r_ja, n_ja;
    logic              r_jzero, n_jzero;
    t_out_item         r_res, n_res;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_odata, n_odata;

    // Memory ports.
    logic              head_we, level_we, cur_we, stack_we, link_we, jump_we;
    logic [IDX_W-1:0]  head_wa, head_ra, level_wa, level_ra, cur_wa, cur_ra;
    logic [IDX_W-1:0]  stack_wa, stack_ra;
    logic [PTR_W-1:0]  head_wd, head_q, cur_wd, cur_q;
    logic [NODE_W-1:0] level_wd, level_q, jump_q, qm;
    logic [SLOT_W-1:0] link_wa, link_ra;
    t_list_entry       link_wd, link_q;
    t_frame            stack_wd, stack_q;
    logic [NODE_W-1:0] jr_node;
    logic [K_W-1:0]    jr_k, jw_k;
    logic [NODE_W-1:0] jw_wd;
    logic [NODE_W-1:0] cnt;
    logic [SLOT_W-1:0] slot0;
    logic [PTR_W-1:0]  ptr0;

    // Node count clamped to the supported range.
    always_comb begin
        if (i_node_count == '0) begin
            cnt = NODE_W'(1);
        end else if (i_node_count > NODE_W'(MAX_NODES)) begin
            cnt = NODE_W'(MAX_NODES);
        end else begin
            cnt = i_node_count;
        end
    end

    assign slot0 = SLOT_W'({r_edges, 1'b0});
    assign ptr0  = PTR_W'({r_edges, 1'b0});
    assign qm    = r_jzero ? '0 : jump_q;

    // Status back to the controller.
    always_comb begin
        o_stat.clr_last   = (r_clr == IDX_W'(MAX_NODES - 1));
        o_stat.kind       = r_kind;
        o_stat.range_bad  = (r_a == '0) || (r_a > cnt) || (r_b == '0) || (r_b > cnt);
        o_stat.have_edges = (r_edges >= cnt - NODE_W'(1));
        o_stat.ready      = r_ready;
        o_stat.edge_ok    = !r_ready && !o_stat.have_edges && !o_stat.range_bad;
        o_stat.same       = (r_a == r_b);
        o_stat.has_root   = (r_a == NODE_W'(1)) || (r_b == NODE_W'(1));
        o_stat.k_last     = (r_k == K_W'(LEVELS - 1));
        o_stat.cur_zero   = (cur_q == '0);
        o_stat.top_one    = (r_top == NODE_W'(1));
        o_stat.lvl_free   = (level_q == '0);
        o_stat.lvl_zero   = (r_la == '0) || (level_q == '0);
        o_stat.gap_bit    = r_gap[r_k];
        o_stat.k_zero     = (r_k == '0);
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

    // Next state of the datapath registers and memory controls.
    always_comb begin
        n_kind = r_kind; n_a = r_a; n_b = r_b; n_edges = r_edges; n_ready = r_ready;
        n_clr = r_clr; n_top = r_top; n_v = r_v; n_up = r_up; n_lvl = r_lvl; n_k = r_k;
        n_tnode = r_tnode; n_tlvl = r_tlvl; n_nb = r_nb; n_la = r_la; n_gap = r_gap;
        n_ja = r_ja; n_res = r_res; n_odata = r_odata;
        n_ovalid = r_ovalid && i_out_stall;

        head_we  = 1'b0; head_wa = IDX_W'(r_a - NODE_W'(1)); head_wd = '0;
        head_ra  = IDX_W'(r_a - NODE_W'(1));
        level_we = 1'b0; level_wa = r_clr; level_wd = '0;
        level_ra = IDX_W'(r_a - NODE_W'(1));
        cur_we   = 1'b0; cur_wa = IDX_W'(r_v - NODE_W'(1)); cur_wd = head_q;
        cur_ra   = IDX_W'(r_tnode - NODE_W'(1));
        stack_we = 1'b0; stack_wa = IDX_W'(r_top); stack_wd = '{node: r_v, lvl: r_lvl};
        stack_ra = IDX_W'(r_top - NODE_W'(2));
        link_we  = 1'b0; link_wa = slot0; link_wd = '{link: head_q, target: r_b};
        link_ra  = SLOT_W'(cur_q - PTR_W'(1));
        jump_we  = 1'b0; jw_k = r_k; jw_wd = qm;
        jr_node  = r_a; jr_k = r_k;

        unique case (i_cmd.op)
            OP_CLR: begin
                head_we = 1'b1; head_wa = r_clr;
                level_we = 1'b1;
                n_clr = r_clr + IDX_W'(1);
            end
            OP_LOAD: begin
                n_kind = i_in_data.kind;
                n_a = i_in_data.node_a;
                n_b = i_in_data.node_b;
            end
            OP_E_RDA: ;
            OP_E_WRA: begin
                link_we = 1'b1;
                head_we = 1'b1; head_wd = ptr0 + PTR_W'(1);
            end
            OP_E_RDB: head_ra = IDX_W'(r_b - NODE_W'(1));
            OP_E_WRB: begin
                link_we = 1'b1; link_wa = slot0 + SLOT_W'(1);
                link_wd = '{link: head_q, target: r_a};
                head_we = 1'b1; head_wa = IDX_W'(r_b - NODE_W'(1));
                head_wd = ptr0 + PTR_W'(2);
                n_edges = r_edges + NODE_W'(1);
            end
            OP_B_INIT: begin
                n_top = '0; n_v = NODE_W'(1); n_up = '0; n_lvl = NODE_W'(1);
            end
            OP_B_ENT: begin
                level_we = 1'b1; level_wa = IDX_W'(r_v - NODE_W'(1)); level_wd = r_lvl;
                jump_we = 1'b1; jw_k = '0; jw_wd = r_up;
                head_ra = IDX_W'(r_v - NODE_W'(1));
                stack_we = 1'b1;
                n_top = r_top + NODE_W'(1);
                n_tnode = r_v; n_tlvl = r_lvl;
                n_k = K_W'(1);
            end
            OP_B_HEAD: begin
                cur_we = 1'b1;
                jr_node = r_up; jr_k = '0;
            end
            OP_B_JWR: begin
                jump_we = 1'b1;
                jr_node = qm; jr_k = r_k;
                n_k = r_k + K_W'(1);
            end
            OP_B_CUR: ;
            OP_B_POP: n_top = r_top - NODE_W'(1);
            OP_B_TOP: begin
                n_tnode = stack_q.node; n_tlvl = stack_q.lvl;
            end
            OP_B_LINK: ;
            OP_B_LNKW: begin
                cur_we = 1'b1; cur_wa = IDX_W'(r_tnode - NODE_W'(1)); cur_wd = link_q.link;
                n_nb = link_q.target;
                level_ra = IDX_W'(link_q.target - NODE_W'(1));
            end
            OP_B_ENTQ: begin
                n_v = r_nb; n_up = r_tnode; n_lvl = r_tlvl + NODE_W'(1);
            end
            OP_B_DONE: begin
                n_ready = 1'b1; n_top = '0;
            end
            OP_Q_BAD:  n_res = '{ancestor: '0, bad_node: 1'b1};
            OP_Q_SAME: n_res = '{ancestor: r_a, bad_node: 1'b0};
            OP_Q_ROOT: n_res = '{ancestor: NODE_W'(1), bad_node: 1'b0};
            OP_Q_ZERO: n_res = '{ancestor: '0, bad_node: 1'b0};
            OP_Q_RDLA: ;
            OP_Q_LVLA: begin
                n_la = level_q;
                level_ra = IDX_W'(r_b - NODE_W'(1));
            end
            OP_Q_LVLB: begin
                // The deeper node moves into a.
                if (r_la < level_q) begin
                    n_a = r_b; n_b = r_a;
                    n_gap = level_q - r_la;
                end else begin
                    n_gap = r_la - level_q;
                end
                n_k = K_W'(LEVELS - 1);
            end
            OP_LIFT: ;
            OP_KDEC: n_k = r_k - K_W'(1);
            OP_LIFTW: begin
                n_a = qm;
                if (r_k != '0) n_k = r_k - K_W'(1);
            end
            OP_CMP_INIT: n_k = K_W'(LEVELS - 1);
            OP_UP_RDA: ;
            OP_UP_RDB: begin
                n_ja = qm;
                jr_node = r_b;
            end
            OP_UP_CMP: begin
                if (r_ja != qm) begin
                    n_a = r_ja; n_b = qm;
                end
                if (r_k != '0) n_k = r_k - K_W'(1);
            end
            OP_FIN_RD: jr_k = '0;
            OP_FIN_W:  n_res = '{ancestor: qm, bad_node: 1'b0};
            OP_EMIT: begin
                n_ovalid = 1'b1;
                n_odata = r_res;
            end
            default: ;
        endcase
    end

    // Node 0 stands above the root, and all of its ancestors read as 0.
    assign n_jzero = (jr_node == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges  <= '0;
            r_ready  <= 1'b0;
            r_clr    <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_edges  <= n_edges;
            r_ready  <= n_ready;
            r_clr    <= n_clr;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b;
        r_v <= n_v; r_up <= n_up; r_lvl <= n_lvl; r_k <= n_k;
        r_tnode <= n_tnode; r_tlvl <= n_tlvl; r_nb <= n_nb;
        r_la <= n_la; r_gap <= n_gap; r_ja <= n_ja; r_jzero <= n_jzero;
        r_res <= n_res; r_odata <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // Memories.
    tlca_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_q)
    );

    tlca_ram #(.WIDTH($bits(t_list_entry)), .DEPTH(2 * MAX_NODES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_ra), .o_rdata(link_q)
    );

    tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_level (
        .i_clk(i_clk), .i_we(level_we), .i_waddr(level_wa), .i_wdata(level_wd),
        .i_raddr(level_ra), .o_rdata(level_q)
    );

    tlca_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_cursor (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(cur_ra), .o_rdata(cur_q)
    );

    tlca_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(stack_wa), .i_wdata(stack_wd),
        .i_raddr(stack_ra), .o_rdata(stack_q)
    );

    tlca_ram #(.WIDTH(NODE_W), .DEPTH(JUMP_DEPTH)) u_jump (
        .i_clk(i_clk), .i_we(jump_we), .i_waddr(jump_addr(r_v, jw_k)), .i_wdata(jw_wd),
        .i_raddr(jump_addr(jr_node, jr_k)), .o_rdata(jump_q)
    );

endmodule

FILE: rtl/core/tlca_ctrl.sv
module tlca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tlca_pkg::t_stat i_stat,
    output tlca_pkg::t_cmd  o_cmd
);
    import tlca_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencing of the clearing pass, edge insertion, tree walk and query.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.kind) begin
                    n_state = i_stat.edge_ok ? S_E_RDA : S_IDLE;
                end else if (i_stat.ready) begin
                    n_state = S_Q_START;
                end else begin
                    n_state = i_stat.have_edges ? S_B_INIT : S_IDLE;
                end
            end
            S_E_RDA: begin o_cmd.op = OP_E_RDA; n_state = S_E_WRA; end
            S_E_WRA: begin o_cmd.op = OP_E_WRA; n_state = S_E_RDB; end
            S_E_RDB: begin o_cmd.op = OP_E_RDB; n_state = S_E_WRB; end
            S_E_WRB: begin o_cmd.op = OP_E_WRB; n_state = S_IDLE; end
            S_B_INIT: begin o_cmd.op = OP_B_INIT; n_state = S_B_ENT; end
            S_B_ENT:  begin o_cmd.op = OP_B_ENT; n_state = S_B_HEAD; end
            S_B_HEAD: begin o_cmd.op = OP_B_HEAD; n_state = S_B_JWR; end
            S_B_JWR: begin
                o_cmd.op = OP_B_JWR;
                if (i_stat.k_last) n_state = S_B_CUR;
            end
            S_B_CUR: begin o_cmd.op = OP_B_CUR; n_state = S_B_CURW; end
            S_B_CURW: begin
                // An empty list pops the node; the last pop ends the walk.
                if (i_stat.cur_zero && i_stat.top_one) begin
                    o_cmd.op = OP_B_DONE;
                    n_state = S_Q_START;
                end else if (i_stat.cur_zero) begin
                    o_cmd.op = OP_B_POP;
                    n_state = S_B_POP;
                end else begin
                    o_cmd.op = OP_B_LINK;
                    n_state = S_B_LNK;
                end
            end
            S_B_POP: begin o_cmd.op = OP_B_TOP; n_state = S_B_CUR; end
            S_B_LNK: begin o_cmd.op = OP_B_LNKW; n_state = S_B_LVL; end
            S_B_LVL: begin
                if (i_stat.lvl_free) begin
                    o_cmd.op = OP_B_ENTQ;
                    n_state = S_B_ENT;
                end else begin
                    n_state = S_B_CUR;
                end
            end
            S_Q_START: begin
                n_state = S_Q_OUT;
                if (i_stat.range_bad) begin
                    o_cmd.op = OP_Q_BAD;
                end else if (i_stat.same) begin
                    o_cmd.op = OP_Q_SAME;
                end else if (i_stat.has_root) begin
                    o_cmd.op = OP_Q_ROOT;
                end else begin
                    o_cmd.op = OP_Q_RDLA;
                    n_state = S_Q_LA;
                end
            end
            S_Q_LA: begin o_cmd.op = OP_Q_LVLA; n_state = S_Q_LB; end
            S_Q_LB: begin
                // A node the walk never reached has no ancestors.
                if (i_stat.lvl_zero) begin
                    o_cmd.op = OP_Q_ZERO;
                    n_state = S_Q_OUT;
                end else begin
                    o_cmd.op = OP_Q_LVLB;
                    n_state = S_Q_LIFT;
                end
            end
            S_Q_LIFT: begin
                if (i_stat.gap_bit) begin
                    o_cmd.op = OP_LIFT;
                    n_state = S_Q_LIFTW;
                end else if (i_stat.k_zero) begin
                    n_state = S_Q_CMP;
                end else begin
                    o_cmd.op = OP_KDEC;
                end
            end
            S_Q_LIFTW: begin
                o_cmd.op = OP_LIFTW;
                n_state = i_stat.k_zero ? S_Q_CMP : S_Q_LIFT;
            end
            S_Q_CMP: begin
                if (i_stat.same) begin
                    o_cmd.op = OP_Q_SAME;
                    n_state = S_Q_OUT;
                end else begin
                    o_cmd.op = OP_CMP_INIT;
                    n_state = S_Q_UA;
                end
            end
            S_Q_UA: begin o_cmd.op = OP_UP_RDA; n_state = S_Q_UB; end
            S_Q_UB: begin o_cmd.op = OP_UP_RDB; n_state = S_Q_UC; end
            S_Q_UC: begin
                o_cmd.op = OP_UP_CMP;
                n_state = i_stat.k_zero ? S_Q_FIN : S_Q_UA;
            end
            S_Q_FIN:  begin o_cmd.op = OP_FIN_RD; n_state = S_Q_FINW; end
            S_Q_FINW: begin o_cmd.op = OP_FIN_W; n_state = S_Q_OUT; end
            S_Q_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: tb/tb_tree_lca_binary_lifting_top.sv
module tb_tree_lca_binary_lifting_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlca_pkg::*;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam int TREE_NODES   = 700;
    localparam int IDLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 24;
    localparam int SLOTS        = 2 * MAX_NODES;

    typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} t_chk;

    typedef struct {
        logic kind;
        int   a;
        int   b;
        t_chk chk;
        int   anc;
        logic bad;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tree_lca_binary_lifting_top i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block: adjacency lists, walk and lifting table.
    int unsigned count_reg;
    int unsigned adj_head[0:MAX_NODES];
    int unsigned adj_link[0:SLOTS-1];
    int unsigned adj_target[0:SLOTS-1];
    int unsigned edge_total;
    int unsigned depth_of[0:MAX_NODES];
    int unsigned hop[0:MAX_NODES][0:LEVELS-1];
    int unsigned dfs_stack[0:MAX_NODES];
    int unsigned dfs_cursor[0:MAX_NODES];
    int unsigned dfs_top;
    bit          tree_built;

    t_out_item   pending_answers[$];
    int          errors;
    int          n_edges;
    int          n_queries;
    int          n_answers;
    int          hold_seq;
    int          hold_seen;
    int          hold_left;
    int          rx_wait;
    bit          rx_quiet;
    bit          tx_quiet;
    int          idle_cycles;

    function automatic int unsigned nodes_in_use();
        if (count_reg < 1) return 1;
        if (count_reg > MAX_NODES) return MAX_NODES;
        return count_reg;
    endfunction

    function automatic void visit_node(int unsigned v, int unsigned up, int unsigned lvl);
        depth_of[v] = lvl;
        hop[v][0] = up;
        for (int k = 1; k < LEVELS; k++) hop[v][k] = hop[hop[v][k-1]][k-1];
        dfs_cursor[v] = adj_head[v];
        if (dfs_top <= MAX_NODES) begin
            dfs_stack[dfs_top] = v;
            dfs_top++;
        end
    endfunction

    // Depth-first walk from the root that fills depths and the jump table.
    function automatic void walk_tree();
        int unsigned t, c, nb;
        for (int v = 0; v <= MAX_NODES; v++) begin
            depth_of[v] = 0;
            for (int k = 0; k < LEVELS; k++) hop[v][k] = 0;
        end
        dfs_top = 0;
        visit_node(1, 0, 1);
        while (dfs_top > 0) begin
            t = dfs_stack[dfs_top-1];
            c = dfs_cursor[t];
            if (c == 0 || c > SLOTS) begin
                dfs_top--;
            end else begin
                dfs_cursor[t] = adj_link[c-1];
                nb = adj_target[c-1];
                if (nb != 0 && nb <= MAX_NODES && depth_of[nb] == 0)
                    visit_node(nb, t, depth_of[t] + 1);
            end
        end
        tree_built = 1'b1;
    endfunction

    function automatic int unsigned lowest_ancestor(int unsigned a, int unsigned b);
        int unsigned gap, tmp;
        if (a == b) return a;
        if (a == 1 || b == 1) return 1;
        if (depth_of[a] < depth_of[b]) begin
            tmp = a;
            a = b;
            b = tmp;
        end
        gap = depth_of[a] - depth_of[b];
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (gap >= (1 << k)) begin
                a = hop[a][k];
                gap -= (1 << k);
            end
        end
        if (a == b) return a;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (hop[a][k] != hop[b][k]) begin
                a = hop[a][k];
                b = hop[b][k];
            end
        end
        return hop[a][0];
    endfunction

    // Applies one request to the shadow state; has_answer tells if a result follows.
    function automatic void apply_request(input t_in_item it, output bit has_answer,
                                          output t_out_item ans);
        int unsigned a, b, cnt, s;
        a = it.node_a;
        b = it.node_b;
        cnt = nodes_in_use();
        has_answer = 1'b0;
        ans = '0;
        if (it.kind == KIND_EDGE) begin
            if (tree_built || edge_total >= cnt - 1) return;
            if (a == 0 || a > cnt || b == 0 || b > cnt) return;
            s = 2 * edge_total;
            adj_target[s] = b;
            adj_link[s] = adj_head[a];
            adj_head[a] = s + 1;
            adj_target[s+1] = a;
            adj_link[s+1] = adj_head[b];
            adj_head[b] = s + 2;
            edge_total++;
            return;
        end
        if (!tree_built) begin
            if (edge_total < cnt - 1) return;
            walk_tree();
        end
        has_answer = 1'b1;
        if (a == 0 || a > cnt || b == 0 || b > cnt) begin
            ans.ancestor = '0;
            ans.bad_node = 1'b1;
        end else begin
            ans.ancestor = NODE_W'(lowest_ancestor(a, b));
            ans.bad_node = 1'b0;
        end
    endfunction

    // Offers a request after a random gap unless tx_quiet; queues any checked answer.
    task automatic send_request(input logic kind, input int a, input int b, input t_chk chk,
                                input int anc, input logic bad);
        int gap;
        t_in_item it;
        bit has_answer;
        t_out_item ans;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        it.kind = kind;
        it.node_a = NODE_W'(a);
        it.node_b = NODE_W'(b);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(it, has_answer, ans);
        if (kind == KIND_EDGE) n_edges++;
        else n_queries++;
        if (chk == CHK_TYPED) begin
            ans.ancestor = NODE_W'(anc);
            ans.bad_node = bad;
            pending_answers = {pending_answers, ans};
        end else if (chk == CHK_MODEL && has_answer) begin
            pending_answers = {pending_answers, ans};
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes node_count and reads it back.
    task automatic set_node_count(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        count_reg = value & 32'h7FF;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[10:0] !== 11'(count_reg)) begin
            $display("%0t node_count readback: expected %0d, got %0d",
                     $time, count_reg, prdata[10:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int pick_node(int hi);
        case ($urandom_range(0, 15))
            0: return $urandom_range(0, 2047);
            1: return 0;
            2: return 1;
            3: return 1024;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    task automatic random_queries(input int n, input int hi);
        int a, b;
        for (int i = 0; i < n; i++) begin
            a = pick_node(hi);
            b = ($urandom_range(0, 7) == 0) ? a : pick_node(hi);
            if ($urandom_range(0, 19) == 0) send_request(KIND_EDGE, a, b, CHK_MODEL, 0, 0);
            else send_request(KIND_QUERY, a, b, CHK_MODEL, 0, 0);
        end
    endtask

    // Result side: checks each result and stalls at random or for a long hold.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t unexpected result: expected none, got anc=%0d bad=%0b",
                             $time, o_out_data.ancestor, o_out_data.bad_node);
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    n_answers++;
                    if (o_out_data.ancestor !== want.ancestor) begin
                        $display("%0t ancestor: expected %0d, got %0d",
                                 $time, want.ancestor, o_out_data.ancestor);
                        errors++;
                    end
                    if (o_out_data.bad_node !== want.bad_node) begin
                        $display("%0t bad_node: expected %0b, got %0b",
                                 $time, want.bad_node, o_out_data.bad_node);
                        errors++;
                    end
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("** tree_lca_binary_lifting_top: FAILED **");
            $finish;
        end
    end

    initial begin
        t_row pre_rows[$];
        t_row post_rows[$];
        int ea[$];
        int eb[$];
        int j, t, v;

        // Before the tree: ignored edges and early queries.
        pre_rows = '{
            '{KIND_EDGE, 0, 5, CHK_NONE, 0, 0},
            '{KIND_EDGE, 5, 0, CHK_NONE, 0, 0},
            '{KIND_EDGE, 701, 3, CHK_NONE, 0, 0},
            '{KIND_EDGE, 1024, 1024, CHK_NONE, 0, 0},
            '{KIND_EDGE, 0, 0, CHK_NONE, 0, 0},
            '{KIND_QUERY, 2, 3, CHK_NONE, 0, 0},
            '{KIND_QUERY, 0, 1024, CHK_NONE, 0, 0}
        };
        // After the tree: short answers, range errors, extra edges.
        post_rows = '{
            '{KIND_QUERY, 1, 1, CHK_TYPED, 1, 0},
            '{KIND_QUERY, 5, 5, CHK_TYPED, 5, 0},
            '{KIND_QUERY, 1, 700, CHK_TYPED, 1, 0},
            '{KIND_QUERY, 700, 1, CHK_TYPED, 1, 0},
            '{KIND_QUERY, 0, 3, CHK_TYPED, 0, 1},
            '{KIND_QUERY, 3, 701, CHK_TYPED, 0, 1},
            '{KIND_QUERY, 1024, 1024, CHK_TYPED, 0, 1},
            '{KIND_QUERY, 0, 0, CHK_TYPED, 0, 1},
            '{KIND_QUERY, 700, 699, CHK_MODEL, 0, 0},
            '{KIND_QUERY, 2, 700, CHK_MODEL, 0, 0},
            '{KIND_QUERY, 699, 2, CHK_MODEL, 0, 0},
            '{KIND_EDGE, 2, 3, CHK_NONE, 0, 0},
            '{KIND_EDGE, 1, 700, CHK_NONE, 0, 0}
        };

        errors = 0;
        n_edges = 0;
        n_queries = 0;
        n_answers = 0;
        hold_seq = 0;
        hold_seen = 0;
        hold_left = 0;
        rx_wait = 0;
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        idle_cycles = 0;
        count_reg = 1;
        edge_total = 0;
        tree_built = 1'b0;
        dfs_top = 0;
        for (int n = 0; n <= MAX_NODES; n++) adj_head[n] = 0;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_node_count(TREE_NODES);
        foreach (pre_rows[r])
            send_request(pre_rows[r].kind, pre_rows[r].a, pre_rows[r].b, pre_rows[r].chk,
                         pre_rows[r].anc, pre_rows[r].bad);

        // Random tree with long chains, shuffled, plus a few cycle and repeated edges.
        for (v = 2; v <= TREE_NODES; v++) begin
            ea = {ea, v};
            eb = {eb, ($urandom_range(0, 1) ? v - 1 : int'($urandom_range(1, v - 1)))};
        end
        for (int i = ea.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ea[i]; ea[i] = ea[j]; ea[j] = t;
            t = eb[i]; eb[i] = eb[j]; eb[j] = t;
        end
        for (int i = 0; i < 4; i++) begin
            j = $urandom_range(0, ea.size() - 1);
            ea[j] = $urandom_range(1, TREE_NODES);
            eb[j] = $urandom_range(1, TREE_NODES);
        end
        j = $urandom_range(1, ea.size() - 1);
        ea[j] = ea[j-1];
        eb[j] = eb[j-1];
        foreach (ea[i]) begin
            if ($urandom_range(0, 15) == 0)
                send_request(KIND_EDGE, $urandom_range(0, 1) ? 0 : $urandom_range(701, 1024),
                             $urandom_range(0, 2047), CHK_MODEL, 0, 0);
            if (i < ea.size() - 1 && $urandom_range(0, 39) == 0)
                send_request(KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
                             CHK_MODEL, 0, 0);
            if ($urandom_range(0, 1)) send_request(KIND_EDGE, ea[i], eb[i], CHK_MODEL, 0, 0);
            else send_request(KIND_EDGE, eb[i], ea[i], CHK_MODEL, 0, 0);
        end
        wait_drained();

        foreach (post_rows[r])
            send_request(post_rows[r].kind, post_rows[r].a, post_rows[r].b, post_rows[r].chk,
                         post_rows[r].anc, post_rows[r].bad);
        random_queries(50, TREE_NODES);

        // Long hold on the result side while requests keep coming back to back.
        hold_seq <= hold_seq + 1;
        tx_quiet = 1'b1;
        random_queries(50, TREE_NODES);
        tx_quiet = 1'b0;
        wait_drained();
        random_queries(30, TREE_NODES);

        // A stretch with no idling on either side.
        rx_quiet <= 1'b1;
        tx_quiet = 1'b1;
        random_queries(30, TREE_NODES);
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
        wait_drained();

        // Largest count, unreached nodes included.
        set_node_count(2047);
        random_queries(50, 1024);
        wait_drained();
        set_node_count(0);
        random_queries(30, 4);
        wait_drained();
        set_node_count(350);
        random_queries(50, TREE_NODES);
        wait_drained();
        set_node_count(1024);
        random_queries(30, 1024);
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d edge requests and %0d queries on a %0d-node tree;",
                 n_edges, n_queries, TREE_NODES);
        $display("%0d results checked across five node_count settings.", n_answers);
        if (errors == 0) begin
            $display("** tree_lca_binary_lifting_top: PASSED **");
        end else begin
            $display("** tree_lca_binary_lifting_top: FAILED **");
        end
        $finish;
    end

endmodule
